// ===== hw/rtl/qra_pkg.sv =====
package qra_pkg;

    localparam int CW_DEFAULT  = 16;
    localparam int HAM_TERMS   = 16;
    localparam int NORM_TERMS  = 4;
    localparam int MAT_TERMS   = 10;
    localparam int MAT_ENTRIES = 9;
    localparam int ROWS        = 3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECIDE, ST_HAM, ST_HAM_DRAIN,
        ST_NSC_INIT, ST_NSC, ST_NSQ, ST_NSQ_DRAIN, ST_NSUM, ST_NSQRT,
        ST_NDIV_LD, ST_NDIV, ST_NDIV_ST,
        ST_MSC_INIT, ST_MSC, ST_MSQ, ST_MSQ_DRAIN, ST_MSUM,
        ST_MDIV_LD, ST_MDIV, ST_MDIV_ST, ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_HAM_MUL, OP_SC_LOAD_P, OP_SC_LOAD_A, OP_SC_STEP,
        OP_NORM_ZERO, OP_SQ_MUL, OP_SUM, OP_SQRT_STEP, OP_DIV_LOAD_N, OP_DIV_LOAD_M,
        OP_DIV_STEP, OP_DIV_STORE_N, OP_DIV_STORE_M, OP_MAT_IDENT, OP_EMIT_ROW
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic acc;        // captured beat is an accumulate
        logic sc_zero;    // all scaled magnitudes zero
        logic sc_ok;      // largest magnitude in [2^29, 2^30)
        logic sqrt_done;
        logic out_free;   // output register can take a row
    } stat_t;

endpackage

// ===== hw/rtl/qra_ctrl.sv =====
module qra_ctrl #(
    parameter int COMPONENT_WIDTH = qra_pkg::CW_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  qra_pkg::stat_t stat,
    output qra_pkg::cmd_t  cmd
);

    localparam int FRAC = COMPONENT_WIDTH - 2;
    localparam int ITW  = $clog2(FRAC);

    qra_pkg::state_t state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [ITW-1:0]  it_reg, it_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qra_pkg::ST_IDLE;
            cnt_reg   <= '0;
            it_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            it_reg    <= it_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        it_next    = it_reg;
        cmd.op     = qra_pkg::OP_NONE;
        cmd.idx    = cnt_reg;
        s_tready   = 1'b0;
        case (state_reg)
            qra_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = qra_pkg::OP_CAPTURE;
                    state_next = qra_pkg::ST_DECIDE;
                end
            end
            qra_pkg::ST_DECIDE: begin
                cnt_next   = '0;
                state_next = stat.acc ? qra_pkg::ST_HAM : qra_pkg::ST_MSC_INIT;
            end
            qra_pkg::ST_HAM: begin
                cmd.op = qra_pkg::OP_HAM_MUL;
                if (cnt_reg == 4'(qra_pkg::HAM_TERMS - 1)) begin
                    cnt_next   = '0;
                    state_next = qra_pkg::ST_HAM_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            qra_pkg::ST_HAM_DRAIN: state_next = qra_pkg::ST_NSC_INIT;
            qra_pkg::ST_NSC_INIT: begin
                cmd.op     = qra_pkg::OP_SC_LOAD_P;
                state_next = qra_pkg::ST_NSC;
            end
            qra_pkg::ST_NSC: begin
                if (stat.sc_zero) begin
                    cmd.op     = qra_pkg::OP_NORM_ZERO;
                    state_next = qra_pkg::ST_MSC_INIT;
                end else if (stat.sc_ok) begin
                    state_next = qra_pkg::ST_NSQ;
                end else begin
                    cmd.op = qra_pkg::OP_SC_STEP;
                end
            end
            qra_pkg::ST_NSQ: begin
                cmd.op = qra_pkg::OP_SQ_MUL;
                if (cnt_reg == 4'(qra_pkg::NORM_TERMS - 1)) begin
                    cnt_next   = '0;
                    state_next = qra_pkg::ST_NSQ_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            qra_pkg::ST_NSQ_DRAIN: state_next = qra_pkg::ST_NSUM;
            qra_pkg::ST_NSUM: begin
                cmd.op     = qra_pkg::OP_SUM;
                state_next = qra_pkg::ST_NSQRT;
            end
            qra_pkg::ST_NSQRT: begin
                if (stat.sqrt_done) begin
                    state_next = qra_pkg::ST_NDIV_LD;
                end else begin
                    cmd.op = qra_pkg::OP_SQRT_STEP;
                end
            end
            qra_pkg::ST_NDIV_LD: begin
                cmd.op     = qra_pkg::OP_DIV_LOAD_N;
                it_next    = '0;
                state_next = qra_pkg::ST_NDIV;
            end
            qra_pkg::ST_NDIV: begin
                cmd.op = qra_pkg::OP_DIV_STEP;
                if (it_reg == ITW'(FRAC - 1)) begin
                    state_next = qra_pkg::ST_NDIV_ST;
                end else begin
                    it_next = it_reg + ITW'(1);
                end
            end
            qra_pkg::ST_NDIV_ST: begin
                cmd.op = qra_pkg::OP_DIV_STORE_N;
                if (cnt_reg == 4'(qra_pkg::NORM_TERMS - 1)) begin
                    cnt_next   = '0;
                    state_next = qra_pkg::ST_MSC_INIT;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = qra_pkg::ST_NDIV_LD;
                end
            end
            qra_pkg::ST_MSC_INIT: begin
                cmd.op     = qra_pkg::OP_SC_LOAD_A;
                cnt_next   = '0;
                state_next = qra_pkg::ST_MSC;
            end
            qra_pkg::ST_MSC: begin
                if (stat.sc_zero) begin
                    cmd.op     = qra_pkg::OP_MAT_IDENT;
                    state_next = qra_pkg::ST_EMIT;
                end else if (stat.sc_ok) begin
                    state_next = qra_pkg::ST_MSQ;
                end else begin
                    cmd.op = qra_pkg::OP_SC_STEP;
                end
            end
            qra_pkg::ST_MSQ: begin
                cmd.op = qra_pkg::OP_SQ_MUL;
                if (cnt_reg == 4'(qra_pkg::MAT_TERMS - 1)) begin
                    cnt_next   = '0;
                    state_next = qra_pkg::ST_MSQ_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            qra_pkg::ST_MSQ_DRAIN: state_next = qra_pkg::ST_MSUM;
            qra_pkg::ST_MSUM: begin
                cmd.op     = qra_pkg::OP_SUM;
                state_next = qra_pkg::ST_MDIV_LD;
            end
            qra_pkg::ST_MDIV_LD: begin
                cmd.op     = qra_pkg::OP_DIV_LOAD_M;
                it_next    = '0;
                state_next = qra_pkg::ST_MDIV;
            end
            qra_pkg::ST_MDIV: begin
                cmd.op = qra_pkg::OP_DIV_STEP;
                if (it_reg == ITW'(FRAC - 1)) begin
                    state_next = qra_pkg::ST_MDIV_ST;
                end else begin
                    it_next = it_reg + ITW'(1);
                end
            end
            qra_pkg::ST_MDIV_ST: begin
                cmd.op = qra_pkg::OP_DIV_STORE_M;
                if (cnt_reg == 4'(qra_pkg::MAT_ENTRIES - 1)) begin
                    cnt_next   = '0;
                    state_next = qra_pkg::ST_EMIT;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = qra_pkg::ST_MDIV_LD;
                end
            end
            qra_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op = qra_pkg::OP_EMIT_ROW;
                    if (cnt_reg == 4'(qra_pkg::ROWS - 1)) begin
                        cnt_next   = '0;
                        state_next = qra_pkg::ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            default: state_next = qra_pkg::ST_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == qra_pkg::OP_EMIT_ROW |-> stat.out_free)
        else $error("row emitted into busy output register");

    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == qra_pkg::ST_DECIDE)
        else $error("accepted beat not followed by decode");

    a_last_row_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == qra_pkg::OP_EMIT_ROW && cnt_reg == 4'(qra_pkg::ROWS - 1)
        |=> state_reg == qra_pkg::ST_IDLE)
        else $error("no return to idle after last row");

endmodule

// ===== hw/rtl/qra_dp.sv =====
module qra_dp #(
    parameter int COMPONENT_WIDTH = qra_pkg::CW_DEFAULT,
    parameter int ITDW = ((4 * COMPONENT_WIDTH + 7) / 8) * 8,
    parameter int OTDW = ((7 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  qra_pkg::cmd_t   cmd,
    output qra_pkg::stat_t  stat,
    input  logic [ITDW-1:0] s_tdata,
    input  logic            s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [OTDW-1:0] m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    localparam int CW   = COMPONENT_WIDTH;
    localparam int FRAC = CW - 2;
    localparam int MW   = (CW > 31) ? CW : 31;    // multiplier operand width
    localparam int PW   = 2 * MW + 2;             // product accumulator
    localparam int SW   = PW - 1;                 // scaler magnitude
    localparam int PRW  = 62;                     // scaled product
    localparam int DW   = 64;                     // divider / root width
    localparam bit DIVQ = (CW > 31);
    localparam logic [15:0] HAM_NEG = 16'h428E;   // subtracted Hamilton terms
    localparam logic signed [CW-1:0] ONE_FX = CW'(1) <<< FRAC;
    localparam logic [FRAC:0] ONE_Q = (FRAC + 1)'(1) << FRAC;

    function automatic logic [1:0] sq_a(input logic [3:0] i);
        case (i)
            4'd0: sq_a = 2'd0;
            4'd1: sq_a = 2'd1;
            4'd2: sq_a = 2'd2;
            4'd3: sq_a = 2'd3;
            4'd4: sq_a = 2'd1;
            4'd5: sq_a = 2'd3;
            4'd6: sq_a = 2'd1;
            4'd7: sq_a = 2'd2;
            4'd8: sq_a = 2'd2;
            4'd9: sq_a = 2'd1;
            default: sq_a = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] sq_b(input logic [3:0] i);
        case (i)
            4'd0: sq_b = 2'd0;
            4'd1: sq_b = 2'd1;
            4'd2: sq_b = 2'd2;
            4'd3: sq_b = 2'd3;
            4'd4: sq_b = 2'd2;
            4'd5: sq_b = 2'd0;
            4'd6: sq_b = 2'd3;
            4'd7: sq_b = 2'd0;
            4'd8: sq_b = 2'd3;
            4'd9: sq_b = 2'd0;
            default: sq_b = 2'd0;
        endcase
    endfunction

    // control state
    logic signed [CW-1:0] orient_reg [4];
    logic                 out_valid_reg;
    qra_pkg::op_t         pend_op_reg;

    // payload
    logic signed [CW-1:0]     b_reg [4];
    logic                     acc_reg;
    logic [3:0]               pend_idx_reg;
    logic signed [2*MW-1:0]   prod_reg;
    logic signed [PW-1:0]     p_reg [4];
    logic [SW-1:0]            sv_reg [4];
    logic                     sgn_reg [4];
    logic signed [PRW-1:0]    pr_reg [10];
    logic [DW-1:0]            sum_reg, sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [DW-1:0]            dr_reg, dden_reg;
    logic [FRAC:0]            dq_reg;
    logic                     dbig_reg, dneg_reg, zero_reg;
    logic signed [CW-1:0]     line_reg [9];
    logic signed [CW-1:0]     out_q_reg [4];
    logic signed [CW-1:0]     out_c_reg [3];
    logic [1:0]               out_row_reg;
    logic                     out_last_reg, out_zero_reg;

    logic signed [CW-1:0] a_eff [4];
    logic signed [30:0]   sval [4];
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] ham_ext, ham_bias, ham_term;
    logic [SW-1:0]        sc_or;
    logic signed [DW-1:0] pe [10];
    logic signed [DW-1:0] e_num;
    logic [DW-1:0]        e_mag, sum_sq, sq_try, num_mag, den_sel;
    logic                 num_neg;
    logic [DW:0]          div_r2;
    logic                 div_ge;
    logic [FRAC:0]        div_f;
    logic signed [CW-1:0] div_val;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            a_eff[j] = orient_reg[j];
            sval[j]  = sgn_reg[j] ? -$signed({1'b0, sv_reg[j][29:0]})
                                  : $signed({1'b0, sv_reg[j][29:0]});
        end
        if (orient_reg[0] == '0 && orient_reg[1] == '0 &&
            orient_reg[2] == '0 && orient_reg[3] == '0) begin
            a_eff[0] = ONE_FX;
        end
    end

    // shared multiplier operand select
    always_comb begin
        if (cmd.op == qra_pkg::OP_HAM_MUL) begin
            mul_a = MW'(a_eff[cmd.idx[1:0]]);
            mul_b = MW'(b_reg[cmd.idx[1:0] ^ cmd.idx[3:2]]);
        end else begin
            mul_a = MW'(sval[sq_a(cmd.idx)]);
            mul_b = MW'(sval[sq_b(cmd.idx)]);
        end
    end

    // Hamilton term, truncated toward zero by 4 when COMPONENT_WIDTH is above 31
    assign ham_ext  = PW'(prod_reg);
    assign ham_bias = ham_ext[PW-1] ? PW'(3) : '0;
    assign ham_term = DIVQ ? ((ham_ext + ham_bias) >>> 2) : ham_ext;

    assign sc_or = sv_reg[0] | sv_reg[1] | sv_reg[2] | sv_reg[3];

    always_comb begin
        for (int k = 0; k < 10; k++) begin
            pe[k] = DW'(pr_reg[k]);
        end
        sum_sq = DW'(pe[0] + pe[1] + pe[2] + pe[3]);
        case (cmd.idx)
            4'd0: e_num = pe[0] + pe[1] - pe[2] - pe[3];
            4'd1: e_num = (pe[4] - pe[5]) <<< 1;
            4'd2: e_num = (pe[6] + pe[7]) <<< 1;
            4'd3: e_num = (pe[4] + pe[5]) <<< 1;
            4'd4: e_num = pe[0] - pe[1] + pe[2] - pe[3];
            4'd5: e_num = (pe[8] - pe[9]) <<< 1;
            4'd6: e_num = (pe[6] - pe[7]) <<< 1;
            4'd7: e_num = (pe[8] + pe[9]) <<< 1;
            4'd8: e_num = pe[0] - pe[1] - pe[2] + pe[3];
            default: e_num = '0;
        endcase
        e_mag = e_num[DW-1] ? DW'(-e_num) : DW'(e_num);
        if (cmd.op == qra_pkg::OP_DIV_LOAD_N) begin
            num_mag = DW'(sv_reg[cmd.idx[1:0]][29:0]);
            num_neg = sgn_reg[cmd.idx[1:0]];
            den_sel = sq_res_reg;
        end else begin
            num_mag = e_mag;
            num_neg = e_num[DW-1];
            den_sel = sum_reg;
        end
    end

    assign sq_try  = sq_res_reg + sq_bit_reg;
    assign div_r2  = {dr_reg, 1'b0};
    assign div_ge  = div_r2 >= {1'b0, dden_reg};
    assign div_f   = dbig_reg ? ONE_Q : dq_reg + (FRAC + 1)'(div_ge);
    assign div_val = dneg_reg ? -$signed(CW'(div_f)) : $signed(CW'(div_f));

    assign stat.acc       = acc_reg;
    assign stat.sc_zero   = (sc_or == '0);
    assign stat.sc_ok     = !(|sc_or[SW-1:30]) && sc_or[29];
    assign stat.sqrt_done = (sq_bit_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 4; j++) begin
                orient_reg[j] <= '0;
            end
            out_valid_reg <= 1'b0;
            pend_op_reg   <= qra_pkg::OP_NONE;
        end else begin
            pend_op_reg <= (cmd.op == qra_pkg::OP_HAM_MUL || cmd.op == qra_pkg::OP_SQ_MUL)
                           ? cmd.op : qra_pkg::OP_NONE;
            if (cmd.op == qra_pkg::OP_CAPTURE && !s_tuser) begin
                for (int j = 0; j < 4; j++) begin
                    orient_reg[j] <= s_tdata[j*CW +: CW];
                end
            end
            if (cmd.op == qra_pkg::OP_NORM_ZERO) begin
                for (int j = 0; j < 4; j++) begin
                    orient_reg[j] <= '0;
                end
            end
            if (cmd.op == qra_pkg::OP_DIV_STORE_N) begin
                orient_reg[cmd.idx[1:0]] <= div_val;
            end
            if (cmd.op == qra_pkg::OP_EMIT_ROW) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= mul_a * mul_b;
        pend_idx_reg <= cmd.idx;
        if (pend_op_reg == qra_pkg::OP_HAM_MUL) begin
            p_reg[pend_idx_reg[3:2]] <= HAM_NEG[pend_idx_reg]
                ? p_reg[pend_idx_reg[3:2]] - ham_term
                : p_reg[pend_idx_reg[3:2]] + ham_term;
        end
        if (pend_op_reg == qra_pkg::OP_SQ_MUL) begin
            pr_reg[pend_idx_reg] <= prod_reg[PRW-1:0];
        end
        case (cmd.op)
            qra_pkg::OP_CAPTURE: begin
                acc_reg <= s_tuser;
                for (int j = 0; j < 4; j++) begin
                    b_reg[j] <= s_tdata[j*CW +: CW];
                    p_reg[j] <= '0;
                end
            end
            qra_pkg::OP_SC_LOAD_P: begin
                for (int j = 0; j < 4; j++) begin
                    sgn_reg[j] <= p_reg[j][PW-1];
                    sv_reg[j]  <= p_reg[j][PW-1] ? SW'(-p_reg[j]) : SW'(p_reg[j]);
                end
            end
            qra_pkg::OP_SC_LOAD_A: begin
                zero_reg <= 1'b0;
                for (int j = 0; j < 4; j++) begin
                    sgn_reg[j] <= orient_reg[j][CW-1];
                    sv_reg[j]  <= orient_reg[j][CW-1]
                                  ? SW'(unsigned'(-(CW+1)'(orient_reg[j])))
                                  : SW'(unsigned'(orient_reg[j]));
                end
            end
            qra_pkg::OP_SC_STEP: begin
                for (int j = 0; j < 4; j++) begin
                    sv_reg[j] <= (|sc_or[SW-1:30]) ? sv_reg[j] >> 1 : sv_reg[j] << 1;
                end
            end
            qra_pkg::OP_SUM: begin
                sum_reg    <= sum_sq;
                sq_x_reg   <= sum_sq;
                sq_res_reg <= '0;
                sq_bit_reg <= DW'(1) << 62;
            end
            qra_pkg::OP_SQRT_STEP: begin
                if (sq_x_reg >= sq_try) begin
                    sq_x_reg   <= sq_x_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            qra_pkg::OP_DIV_LOAD_N, qra_pkg::OP_DIV_LOAD_M: begin
                dr_reg   <= num_mag;
                dden_reg <= den_sel;
                dq_reg   <= '0;
                dbig_reg <= num_mag >= den_sel;
                dneg_reg <= num_neg;
            end
            qra_pkg::OP_DIV_STEP: begin
                if (div_ge) begin
                    dr_reg <= DW'(div_r2 - {1'b0, dden_reg});
                end else begin
                    dr_reg <= div_r2[DW-1:0];
                end
                dq_reg <= {dq_reg[FRAC-1:0], div_ge};
            end
            qra_pkg::OP_DIV_STORE_M: begin
                for (int k = 0; k < 8; k++) begin
                    line_reg[k] <= line_reg[k+1];
                end
                line_reg[8] <= div_val;
            end
            qra_pkg::OP_MAT_IDENT: begin
                zero_reg <= 1'b1;
                for (int k = 0; k < 9; k++) begin
                    line_reg[k] <= (k % 4 == 0) ? ONE_FX : '0;
                end
            end
            qra_pkg::OP_EMIT_ROW: begin
                for (int j = 0; j < 4; j++) begin
                    out_q_reg[j] <= orient_reg[j];
                end
                for (int k = 0; k < 3; k++) begin
                    out_c_reg[k] <= line_reg[k];
                end
                for (int k = 0; k < 6; k++) begin
                    line_reg[k] <= line_reg[k+3];
                end
                out_row_reg  <= cmd.idx[1:0];
                out_last_reg <= (cmd.idx == 4'(qra_pkg::ROWS - 1));
                out_zero_reg <= zero_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_zero_reg, out_row_reg};
    assign m_tdata  = OTDW'({out_c_reg[2], out_c_reg[1], out_c_reg[0],
                             out_q_reg[3], out_q_reg[2], out_q_reg[1], out_q_reg[0]});

    a_root_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == qra_pkg::OP_SQRT_STEP |-> $onehot(sq_bit_reg))
        else $error("root bit register not one-hot");

    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == qra_pkg::OP_DIV_STORE_M || cmd.op == qra_pkg::OP_DIV_STORE_N
        |-> div_f <= ONE_Q)
        else $error("quotient above one");

    a_zero_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_zero_reg |->
        out_c_reg[0] == ((out_row_reg == 2'd0) ? ONE_FX : '0) &&
        out_c_reg[1] == ((out_row_reg == 2'd1) ? ONE_FX : '0) &&
        out_c_reg[2] == ((out_row_reg == 2'd2) ? ONE_FX : '0))
        else $error("zero-length row is not identity");

endmodule

// ===== hw/rtl/quaternion_rotation_accumulator_top.sv =====
// Channel | Dir | tdata (low bit up)                          | tuser / tlast
// s_      | in  | in_w, in_x, in_y, in_z                      | tuser: command
// m_      | out | q_w, q_x, q_y, q_z, m_c0, m_c1, m_c2        | tuser: row, zero_length;
//         |     |                                             | tlast: last
//
// One beat at a time. A load beat scales its quaternion, squares it and divides out the nine
// matrix entries; an accumulate first forms the Hamilton product and normalizes it. The
// normalizing shift runs one bit per cycle, the square root runs 32 steps, every quotient is a
// restoring divide of FRAC steps. One shared multiplier does all 16 + 4 + 10 products.
// Reset clears the orientation to zero and empties the output register.
// s_tready is high only in idle; the third row may still wait in the output
// register while the next beat is taken. m_ stalls only hold the row sequence.
module quaternion_rotation_accumulator_top #(
    parameter int COMPONENT_WIDTH = qra_pkg::CW_DEFAULT,
    parameter int ITDW = ((4 * COMPONENT_WIDTH + 7) / 8) * 8,
    parameter int OTDW = ((7 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [ITDW-1:0] s_tdata,   // in_w, in_x, in_y, in_z
    input  logic            s_tuser,   // command: 0 load, 1 accumulate
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [OTDW-1:0] m_tdata,   // q_w, q_x, q_y, q_z, m_c0, m_c1, m_c2
    output logic [2:0]      m_tuser,   // row[1:0], zero_length
    output logic            m_tlast    // last row of the three
);

    qra_pkg::cmd_t  cmd;
    qra_pkg::stat_t stat;

    // sequencer: walks product, scale, square, root, divide and emit phases
    qra_ctrl #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: orientation, shared multiplier, scaler, root, divider, row line
    qra_dp #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH),
        .ITDW           (ITDW),
        .OTDW           (OTDW)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
